/* rtl/color_sorter_gate_controller_core_macros.svh */
// Assertion macros shared by the colour sorter gate controller modules.
`ifndef COLOR_SORTER_GATE_CONTROLLER_CORE_MACROS_SVH
`define COLOR_SORTER_GATE_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CSGC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/csgc_pkg.sv */
// Types, codes and constants of the colour sorter gate controller.
`timescale 1ns / 1ps
package csgc_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 8;
  localparam int unsigned FRONT_STAGES = 3;

  localparam logic [3:0] REG_REF_RED    = 4'd0;
  localparam logic [3:0] REG_REF_GREEN  = 4'd1;
  localparam logic [3:0] REG_REF_WHITE  = 4'd2;
  localparam logic [3:0] REG_REF_YELLOW = 4'd3;
  localparam logic [3:0] REG_PROX_THR   = 4'd4;
  localparam logic [3:0] REG_DWELL_MS   = 4'd5;
  localparam logic [3:0] REG_ACCEPT_MS  = 4'd6;
  localparam logic [3:0] REG_REJECT_MS  = 4'd7;

  localparam logic [1:0] COL_RED    = 2'd0;
  localparam logic [1:0] COL_GREEN  = 2'd1;
  localparam logic [1:0] COL_WHITE  = 2'd2;
  localparam logic [1:0] COL_YELLOW = 2'd3;

  localparam logic [1:0] GATE_NEUTRAL = 2'd0;
  localparam logic [1:0] GATE_ACCEPT  = 2'd1;
  localparam logic [1:0] GATE_REJECT  = 2'd2;

  typedef enum logic [1:0] {
    PH_NEUTRAL = 2'd0,
    PH_DWELL   = 2'd1,
    PH_ACCEPT  = 2'd2,
    PH_REJECT  = 2'd3
  } csgc_phase_t;

  // Reference colours, red in bits 47..32, green in 31..16, blue in 15..0.
  typedef logic [3:0][47:0] csgc_refs_t;

  typedef struct packed {
    logic [15:0] prox_thr;
    logic [31:0] dwell_ms;
    logic [31:0] accept_ms;
    logic [31:0] reject_ms;
  } csgc_timing_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        sel_red;
    logic        sel_green;
    logic        sel_white;
    logic        sel_yellow;
    logic [15:0] proximity;
    logic [15:0] red_count;
    logic [15:0] green_count;
    logic [15:0] blue_count;
  } csgc_in_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        sel_red;
    logic        sel_green;
    logic        sel_white;
    logic        sel_yellow;
    logic [15:0] proximity;
    logic [1:0]  colour;
  } csgc_item_t;

  typedef struct packed {
    logic       valid;
    csgc_item_t item;
  } csgc_push_t;

  typedef struct packed {
    csgc_phase_t phase;
    logic        gate_write;
    logic [1:0]  gate_position;
    logic [1:0]  sensed_colour;
    logic        colour_valid;
    logic [1:0]  team_colour_out;
  } csgc_result_t;

endpackage

/* rtl/csgc_fifo.sv */
// Short queue that carries classified words from the front to the back.
`timescale 1ns / 1ps
`include "color_sorter_gate_controller_core_macros.svh"
module csgc_fifo #(
  parameter int unsigned DEPTH = csgc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  csgc_pkg::csgc_push_t         push,
  input  logic                         pop,
  output csgc_pkg::csgc_item_t         head,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  csgc_pkg::csgc_item_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push.valid && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!push.valid && pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

  `CSGC_ASSERT_NOW(a_no_overflow, push.valid && !pop, cnt_r < CW'(DEPTH), "queue overflow")

endmodule

/* rtl/csgc_front.sv */
// Front pipeline: absolute differences, squares, distance sums and nearest colour.
`timescale 1ns / 1ps
module csgc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_acc,
  input  csgc_pkg::csgc_in_t    in_word,
  input  csgc_pkg::csgc_refs_t  refs,
  output csgc_pkg::csgc_push_t  push,
  output logic [1:0]            busy_cnt
);

  logic [2:0] v_r;

  csgc_pkg::csgc_item_t s1_r, s2_r, s3_r;

  logic [3:0][2:0][15:0] diff_nxt, diff_r;
  logic [3:0][2:0][31:0] sq_nxt, sq_r;
  logic [3:0][33:0]      sum_nxt, sum_r;

  logic [2:0][15:0] sample;
  logic [15:0]      ref_ch;
  logic [33:0]      min_a, min_b;
  logic [1:0]       idx_a, idx_b, best;

  always_comb begin
    sample[0] = in_word.red_count;
    sample[1] = in_word.green_count;
    sample[2] = in_word.blue_count;
    ref_ch    = '0;
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 3; c++) begin
        ref_ch = refs[k][47 - 16 * c -: 16];
        diff_nxt[k][c] = (sample[c] >= ref_ch) ? (sample[c] - ref_ch) : (ref_ch - sample[c]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 3; c++) begin
        sq_nxt[k][c] = {16'b0, diff_r[k][c]} * {16'b0, diff_r[k][c]};
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum_nxt[k] = 34'(sq_r[k][0]) + 34'(sq_r[k][1]) + 34'(sq_r[k][2]);
    end
  end

  // Ties keep the earlier colour at every level of the tree.
  always_comb begin
    if (sum_r[1] < sum_r[0]) begin
      min_a = sum_r[1];
      idx_a = csgc_pkg::COL_GREEN;
    end else begin
      min_a = sum_r[0];
      idx_a = csgc_pkg::COL_RED;
    end
    if (sum_r[3] < sum_r[2]) begin
      min_b = sum_r[3];
      idx_b = csgc_pkg::COL_YELLOW;
    end else begin
      min_b = sum_r[2];
      idx_b = csgc_pkg::COL_WHITE;
    end
    best = (min_b < min_a) ? idx_b : idx_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[1:0], in_acc};
    end
  end

  always_ff @(posedge clk) begin
    s1_r.now_ms     <= in_word.now_ms;
    s1_r.sel_red    <= in_word.sel_red;
    s1_r.sel_green  <= in_word.sel_green;
    s1_r.sel_white  <= in_word.sel_white;
    s1_r.sel_yellow <= in_word.sel_yellow;
    s1_r.proximity  <= in_word.proximity;
    s1_r.colour     <= csgc_pkg::COL_RED;
    diff_r          <= diff_nxt;
    s2_r            <= s1_r;
    sq_r            <= sq_nxt;
    s3_r            <= s2_r;
    sum_r           <= sum_nxt;
  end

  always_comb begin
    push.valid       = v_r[2];
    push.item        = s3_r;
    push.item.colour = best;
  end

  assign busy_cnt = 2'(v_r[0]) + 2'(v_r[1]) + 2'(v_r[2]);

endmodule

/* rtl/csgc_back.sv */
// Back end: team colour, phase machine, gate timing and the output register.
`timescale 1ns / 1ps
`include "color_sorter_gate_controller_core_macros.svh"
module csgc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  csgc_pkg::csgc_item_t   item,
  input  logic                   empty,
  output logic                   pop,
  input  csgc_pkg::csgc_timing_t timing,
  output logic                   out_valid,
  input  logic                   out_ready,
  output csgc_pkg::csgc_result_t out_word
);

  csgc_pkg::csgc_phase_t phase_r, phase_nxt;
  logic [1:0]  team_r, team_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] elapsed;
  logic        out_valid_r;
  csgc_pkg::csgc_result_t out_r, res_nxt;
  logic        gate_write;
  logic [1:0]  gate_pos;
  logic        colour_valid;

  assign pop     = !empty && (!out_valid_r || out_ready);
  assign elapsed = item.now_ms - start_r;

  always_comb begin
    priority if (item.sel_yellow) begin
      team_nxt = csgc_pkg::COL_YELLOW;
    end else if (item.sel_white) begin
      team_nxt = csgc_pkg::COL_WHITE;
    end else if (item.sel_green) begin
      team_nxt = csgc_pkg::COL_GREEN;
    end else if (item.sel_red) begin
      team_nxt = csgc_pkg::COL_RED;
    end else begin
      team_nxt = team_r;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    start_nxt = start_r;
    unique case (phase_r)
      csgc_pkg::PH_NEUTRAL: begin
        if (item.proximity > timing.prox_thr) begin
          phase_nxt = csgc_pkg::PH_DWELL;
          start_nxt = item.now_ms;
        end
      end
      csgc_pkg::PH_DWELL: begin
        if (elapsed > timing.dwell_ms) begin
          phase_nxt = (item.colour == team_nxt) ? csgc_pkg::PH_ACCEPT : csgc_pkg::PH_REJECT;
          start_nxt = item.now_ms;
        end
      end
      csgc_pkg::PH_ACCEPT: begin
        if (elapsed > timing.accept_ms) begin
          phase_nxt = csgc_pkg::PH_NEUTRAL;
        end
      end
      csgc_pkg::PH_REJECT: begin
        if (elapsed > timing.reject_ms) begin
          phase_nxt = csgc_pkg::PH_NEUTRAL;
        end
      end
      default: begin
        phase_nxt = csgc_pkg::PH_NEUTRAL;
      end
    endcase
  end

  always_comb begin
    gate_write   = 1'b0;
    gate_pos     = csgc_pkg::GATE_NEUTRAL;
    colour_valid = 1'b0;
    unique case (phase_r)
      csgc_pkg::PH_NEUTRAL: begin
      end
      csgc_pkg::PH_DWELL: begin
        if (elapsed > timing.dwell_ms) begin
          gate_write   = 1'b1;
          colour_valid = 1'b1;
          gate_pos     = (item.colour == team_nxt) ? csgc_pkg::GATE_ACCEPT
                                                   : csgc_pkg::GATE_REJECT;
        end
      end
      csgc_pkg::PH_ACCEPT: begin
        gate_write = (elapsed > timing.accept_ms);
      end
      csgc_pkg::PH_REJECT: begin
        gate_write = (elapsed > timing.reject_ms);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_nxt.phase           = phase_nxt;
    res_nxt.gate_write      = gate_write;
    res_nxt.gate_position   = gate_pos;
    res_nxt.sensed_colour   = colour_valid ? item.colour : csgc_pkg::COL_RED;
    res_nxt.colour_valid    = colour_valid;
    res_nxt.team_colour_out = team_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= csgc_pkg::PH_NEUTRAL;
      team_r      <= csgc_pkg::COL_RED;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r <= phase_nxt;
        team_r  <= team_nxt;
        start_r <= start_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  `CSGC_ASSERT_NOW(a_colour_opens_gate, out_valid_r && out_r.colour_valid, out_r.gate_write && (out_r.phase == csgc_pkg::PH_ACCEPT || out_r.phase == csgc_pkg::PH_REJECT), "classification without gate command")
  `CSGC_ASSERT_NOW(a_idle_gate_neutral, out_valid_r && !out_r.gate_write, out_r.gate_position == csgc_pkg::GATE_NEUTRAL, "gate position without command")
  `CSGC_ASSERT_NOW(a_accept_matches_team, out_valid_r && out_r.colour_valid && out_r.phase == csgc_pkg::PH_ACCEPT, out_r.sensed_colour == out_r.team_colour_out, "accept on colour mismatch")
  `CSGC_ASSERT_NEXT(a_dwell_holds, pop && phase_r == csgc_pkg::PH_DWELL && !(elapsed > timing.dwell_ms), phase_r == csgc_pkg::PH_DWELL, "dwell left early")

endmodule

/* rtl/color_sorter_gate_controller_core.sv */
// Top level of the colour sorter gate controller.
`timescale 1ns / 1ps
// A word accepted on the input stream yields exactly one result word, and the block
// sustains one word per cycle unless the output stalls. The front runs a three-stage
// pipeline (channel differences, squares, distance sums) and picks the nearest reference
// colour as the word enters a queue of QUEUE_DEPTH words; the back runs the phase machine
// on one word per cycle, unless the output stalls, into a single output register. The
// input is ready while the words held in the front pipeline and the queue number fewer
// than QUEUE_DEPTH, so a stalled output backs up into the queue before it stops the input.
// Configuration registers are to be written only while no word is in flight.
module color_sorter_gate_controller_core #(
  parameter int unsigned QUEUE_DEPTH = csgc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // now_ms[31:0], select_red[32], select_green[33], select_white[34], select_yellow[35],
  // proximity[51:36], red_count[67:52], green_count[83:68], blue_count[99:84], zeros above.
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // phase[1:0], gate_write[2], gate_position[4:3], sensed_colour[6:5], colour_valid[7],
  // team_colour_out[9:8], zeros above.
  output logic [15:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_addr,
  input  logic [47:0]  cfg_wdata
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OW = CW + 2;

  csgc_pkg::csgc_refs_t   refs_r;
  csgc_pkg::csgc_timing_t timing_r;
  csgc_pkg::csgc_in_t     in_word;
  csgc_pkg::csgc_push_t   push;
  csgc_pkg::csgc_item_t   head;
  csgc_pkg::csgc_result_t res;
  logic                   q_empty;
  logic                   pop;
  logic [CW-1:0]          q_cnt;
  logic [1:0]             busy_cnt;
  logic [OW-1:0]          occupancy;
  logic                   in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refs_r             <= '0;
      timing_r.prox_thr  <= 16'hFFFF;
      timing_r.dwell_ms  <= '0;
      timing_r.accept_ms <= '0;
      timing_r.reject_ms <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        csgc_pkg::REG_REF_RED:    refs_r[0] <= cfg_wdata;
        csgc_pkg::REG_REF_GREEN:  refs_r[1] <= cfg_wdata;
        csgc_pkg::REG_REF_WHITE:  refs_r[2] <= cfg_wdata;
        csgc_pkg::REG_REF_YELLOW: refs_r[3] <= cfg_wdata;
        csgc_pkg::REG_PROX_THR:   timing_r.prox_thr  <= cfg_wdata[15:0];
        csgc_pkg::REG_DWELL_MS:   timing_r.dwell_ms  <= cfg_wdata[31:0];
        csgc_pkg::REG_ACCEPT_MS:  timing_r.accept_ms <= cfg_wdata[31:0];
        csgc_pkg::REG_REJECT_MS:  timing_r.reject_ms <= cfg_wdata[31:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_word.now_ms      = in_tdata[31:0];
    in_word.sel_red     = in_tdata[32];
    in_word.sel_green   = in_tdata[33];
    in_word.sel_white   = in_tdata[34];
    in_word.sel_yellow  = in_tdata[35];
    in_word.proximity   = in_tdata[51:36];
    in_word.red_count   = in_tdata[67:52];
    in_word.green_count = in_tdata[83:68];
    in_word.blue_count  = in_tdata[99:84];
  end

  assign occupancy = OW'(q_cnt) + OW'(busy_cnt);
  assign in_tready = (occupancy < OW'(QUEUE_DEPTH));
  assign in_acc    = in_tvalid && in_tready;

  csgc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .in_word  (in_word),
    .refs     (refs_r),
    .push     (push),
    .busy_cnt (busy_cnt)
  );

  csgc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .empty (q_empty),
    .count (q_cnt)
  );

  csgc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (head),
    .empty     (q_empty),
    .pop       (pop),
    .timing    (timing_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (res)
  );

  assign out_tdata = {6'b0, res.team_colour_out, res.colour_valid, res.sensed_colour,
                      res.gate_position, res.gate_write, res.phase};

endmodule
